// ===== design/largest_one_bordered_square_core_assert.svh =====
// Assertion macros used by the checker module of this block.
// Every macro samples on the rising edge of clk; all but the reset form
// are disabled while rst is high.
`ifndef LARGEST_ONE_BORDERED_SQUARE_CORE_ASSERT_SVH
`define LARGEST_ONE_BORDERED_SQUARE_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define LOBS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lobs checker: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define LOBS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lobs checker: same-cycle property failed");

// The consequent must hold in the cycle after reset is sampled high.
`define LOBS_ASSERT_RESET(lbl, post) \
  lbl: assert property (@(posedge clk) rst |=> (post)) \
    else $error("lobs checker: reset property failed");

`endif

// ===== design/lobs_pkg.sv =====
`timescale 1ns / 1ps

package lobs_pkg;

  // Field widths of the stream payloads.
  localparam int COUNT_W    = 7;
  localparam int SIDE_W     = 7;
  localparam int AREA_W     = 13;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 24;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

endpackage

// ===== design/largest_one_bordered_square_core.sv =====
`timescale 1ns / 1ps
// Largest square bordered by ones.
// The slave stream takes one matrix cell per transaction in raster order,
// cell value in s_tdata[0]. After the last cell of a row_count by col_count
// matrix, one transaction on the master stream carries the largest side of a
// square whose border is all ones, and its area.
// The APB port holds row_count (address 0) and col_count (address 4); any
// write restarts the matrix, and the input is held off in the write cycle.
// Counts of zero act as one, counts above MAX_DIM act as MAX_DIM.
// Each accepted cell passes through the READ, CALC and DONE states before the
// next cell can be accepted. A cell that tries candidate sides (at most
// MAX_DIM) also passes through TEST and CHECK, where one candidate is checked
// per cycle, since the run-length memories have one read port each.
// m_tvalid is registered from the DONE state of the last cell of a matrix. A
// pending result does not block new cells; only when a new result is due
// while the previous one is still stalled does the core wait. Reset returns
// both counts to MAX_DIM (capped at 127), clears the position and best side,
// and drops m_tvalid. The run memories need no clearing, since every entry
// is written before it is read within a matrix.

module largest_one_bordered_square_core #(
  parameter int MAX_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: [0] cell_bit, [7:1] zero.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lobs_pkg::S_TDATA_W-1:0]    s_tdata,
  // m_tdata: [6:0] best_side, [19:7] best_area, [23:20] zero.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lobs_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lobs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lobs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lobs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  import lobs_pkg::*;

  localparam int PosW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CntW  = $clog2(MAX_DIM + 1);
  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountReset = (MAX_DIM > 127) ? 127 : MAX_DIM;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_TEST,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t               state;
  logic [PosW-1:0]      row_pos;
  logic [PosW-1:0]      col_pos;
  logic [CntW-1:0]      best;
  logic [CntW-1:0]      cand;
  logic                 cell_bit;
  logic [COUNT_W-1:0]   row_count;
  logic [COUNT_W-1:0]   col_count;
  logic                 out_valid;
  logic [SIDE_W-1:0]    out_side;
  logic [AREA_W-1:0]    out_area;

  logic [CntW-1:0]      rows_eff;
  logic [CntW-1:0]      cols_eff;
  logic [AddrW-1:0]     up_raddr;
  logic [AddrW-1:0]     left_raddr;
  logic [AddrW-1:0]     waddr;
  logic [CntW-1:0]      up_rd;
  logic [CntW-1:0]      left_rd;
  logic [CntW-1:0]      up_val;
  logic [CntW-1:0]      left_val;
  logic [CntW-1:0]      limit;
  logic                 mem_we;
  logic                 cfg_wr;
  logic                 last_col;
  logic                 last_row;
  logic                 emit;

  function automatic logic [CntW-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    int x;
    x = int'(v);
    if (x < 1) begin
      x = 1;
    end else if (x > MAX_DIM) begin
      x = MAX_DIM;
    end
    return CntW'(x);
  endfunction

  function automatic logic [AddrW-1:0] addr_of(input int r, input int c);
    return AddrW'(r * MAX_DIM + c);
  endfunction

  assign rows_eff = clamp_count(row_count);
  assign cols_eff = clamp_count(col_count);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE) && !cfg_wr;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W - SIDE_W - AREA_W){1'b0}}, out_area, out_side};

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_ROW_COUNT: prdata = {{(CFG_DATA_W - COUNT_W){1'b0}}, row_count};
      REG_COL_COUNT: prdata = {{(CFG_DATA_W - COUNT_W){1'b0}}, col_count};
      default:       prdata = '0;
    endcase
  end

  // Read addresses: neighbor runs while reading, candidate corners while testing.
  always_comb begin
    int k;
    int r;
    int c;
    r = int'(row_pos);
    c = int'(col_pos);
    k = (state == ST_CHECK) ? int'(cand) - 1 : int'(cand);
    if (state == ST_READ) begin
      up_raddr   = addr_of(r - 1, c);
      left_raddr = addr_of(r, c - 1);
    end else begin
      up_raddr   = addr_of(r, c - (k - 1));
      left_raddr = addr_of(r - (k - 1), c);
    end
  end

  // New run lengths for the current cell and the first candidate side.
  always_comb begin
    if (!cell_bit) begin
      up_val   = '0;
      left_val = '0;
    end else begin
      up_val   = (row_pos != '0) ? up_rd + CntW'(1) : CntW'(1);
      left_val = (col_pos != '0) ? left_rd + CntW'(1) : CntW'(1);
    end
    limit = (up_val < left_val) ? up_val : left_val;
  end

  assign mem_we   = (state == ST_CALC);
  assign waddr    = addr_of(int'(row_pos), int'(col_pos));
  assign last_col = (CntW'(col_pos) + CntW'(1)) >= cols_eff;
  assign last_row = (CntW'(row_pos) + CntW'(1)) >= rows_eff;

  // The last cell of a matrix hands its result over once the output is free.
  assign emit = (state == ST_DONE) && last_col && last_row && !cfg_wr &&
                (!out_valid || m_tready);

  lobs_ram #(
    .WIDTH (CntW),
    .DEPTH (Depth)
  ) u_up_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (up_val),
    .raddr (up_raddr),
    .rdata (up_rd)
  );

  lobs_ram #(
    .WIDTH (CntW),
    .DEPTH (Depth)
  ) u_left_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (left_val),
    .raddr (left_raddr),
    .rdata (left_rd)
  );

  // Cell sequencer, result register and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_pos   <= '0;
      col_pos   <= '0;
      best      <= '0;
      out_valid <= 1'b0;
      row_count <= COUNT_W'(CountReset);
      col_count <= COUNT_W'(CountReset);
    end else begin
      // The result is held until the receiver takes it.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr) begin
        // A register write restarts the matrix.
        unique case (paddr[2])
          REG_ROW_COUNT: row_count <= pwdata[COUNT_W-1:0];
          REG_COL_COUNT: col_count <= pwdata[COUNT_W-1:0];
          default:       row_count <= row_count;
        endcase
        row_pos <= '0;
        col_pos <= '0;
        best    <= '0;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (s_tvalid) begin
              cell_bit <= s_tdata[0];
              state    <= ST_READ;
              if (CntW'(row_pos) >= rows_eff || CntW'(col_pos) >= cols_eff) begin
                row_pos <= '0;
                col_pos <= '0;
                best    <= '0;
              end
            end
          end
          ST_READ: begin
            state <= ST_CALC;
          end
          ST_CALC: begin
            cand <= limit;
            if (limit > best) begin
              state <= ST_TEST;
            end else begin
              state <= ST_DONE;
            end
          end
          ST_TEST: begin
            state <= ST_CHECK;
          end
          ST_CHECK: begin
            if (up_rd >= cand && left_rd >= cand) begin
              best  <= cand;
              state <= ST_DONE;
            end else if ((cand - CntW'(1)) > best) begin
              cand <= cand - CntW'(1);
            end else begin
              state <= ST_DONE;
            end
          end
          ST_DONE: begin
            if (!last_col) begin
              col_pos <= col_pos + PosW'(1);
              state   <= ST_IDLE;
            end else if (!last_row) begin
              col_pos <= '0;
              row_pos <= row_pos + PosW'(1);
              state   <= ST_IDLE;
            end else if (emit) begin
              out_side <= SIDE_W'(best);
              out_area <= AREA_W'(int'(best) * int'(best));
              row_pos  <= '0;
              col_pos  <= '0;
              best     <= '0;
              state    <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/lobs_ram.sv =====
`timescale 1ns / 1ps

module lobs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lobs_checker.sv =====
`timescale 1ns / 1ps
`include "largest_one_bordered_square_core_assert.svh"

module lobs_checker #(
  parameter int MAX_DIM = 64
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [lobs_pkg::M_TDATA_W-1:0]    m_tdata
);

  import lobs_pkg::*;

  logic [AREA_W-1:0] side_sq;

  // Square of the reported side, for the area check.
  assign side_sq = AREA_W'(m_tdata[SIDE_W-1:0]) * AREA_W'(m_tdata[SIDE_W-1:0]);

  // A stalled result transaction holds its payload.
  `LOBS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The area field is the square of the side field.
  `LOBS_ASSERT_NOW(a_area_square, m_tvalid, m_tdata[SIDE_W+AREA_W-1:SIDE_W] == side_sq)

  // No square can be wider than the largest matrix.
  `LOBS_ASSERT_NOW(a_side_bound, m_tvalid, int'(m_tdata[SIDE_W-1:0]) <= MAX_DIM)

  // A cell is worked on before the next is taken, so s_tready drops after each accepted cell.
  `LOBS_ASSERT_NEXT(a_busy_after_cell, s_tvalid && s_tready, !s_tready)

  // Out of reset the core is ready and holds no result.
  `LOBS_ASSERT_RESET(a_reset_state, s_tready && !m_tvalid)

endmodule

bind largest_one_bordered_square_core lobs_checker #(
  .MAX_DIM (MAX_DIM)
) u_lobs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
